FILE: rtl/audio_class_control_responder_top_defines.svh
// ----------------------------------------------------------------------------
// Audio class control responder: assertion macros
// Shared property wrappers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_CLASS_CONTROL_RESPONDER_TOP_DEFINES_SVH
`define AUDIO_CLASS_CONTROL_RESPONDER_TOP_DEFINES_SVH

// same-cycle implication
`define ACC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Types, request codes and constants of the audio class control responder.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

  localparam int ACC_MAX_DATA_LENGTH = 64;

  // request codes (UAC1)
  localparam logic [7:0] REQ_SET_CUR = 8'h01;
  localparam logic [7:0] REQ_GET_CUR = 8'h81;
  localparam logic [7:0] REQ_GET_MIN = 8'h82;
  localparam logic [7:0] REQ_GET_MAX = 8'h83;
  localparam logic [7:0] REQ_GET_RES = 8'h84;

  localparam logic [1:0] TYPE_CLASS   = 2'b01;
  localparam logic [4:0] RCP_IFACE    = 5'd1;
  localparam logic [4:0] RCP_ENDPOINT = 5'd2;
  localparam logic [7:0] SEL_MUTE     = 8'd1;
  localparam logic [7:0] SEL_VOLUME   = 8'd2;
  localparam logic [7:0] SEL_RATE     = 8'd1;

  // volume in signed 8.8 dB
  localparam logic signed [15:0] VOL_MIN_DB256 = -16'sd23040;
  localparam logic [15:0]        VOL_MAX_DB256 = 16'd0;
  localparam logic [15:0]        VOL_RES_DB256 = 16'd256;
  localparam logic [14:0]        VOL_SPAN      = 15'd23040;
  // 65536/9 rounded up, exact floor(t/9) for t <= 900
  localparam logic [12:0]        DIV9_RECIP    = 13'd7282;
  localparam logic [6:0]         PCT_RESET     = 7'd100;

  localparam logic [15:0] RATE_LOW    = 16'd44100;
  localparam logic [15:0] RATE_HIGH   = 16'd48000;
  localparam logic [19:0] FB_LOW      = 20'd722534;
  localparam logic [19:0] FB_HIGH     = 20'd786432;

  typedef enum logic [1:0] {
    ST_REPLY  = 2'd0,
    ST_WAIT   = 2'd1,
    ST_STALL  = 2'd2,
    ST_CLOSED = 2'd3
  } acc_status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] length_word;
    logic [5:0]  data_count;
    logic [23:0] payload;
  } acc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] reply_data;
    logic [1:0]  reply_len;
    logic        mute_now;
    logic [6:0]  vol_percent;
    logic [15:0] sample_rate;
    logic [19:0] feedback_word;
  } acc_out_t;

endpackage

`default_nettype wire

FILE: rtl/acc_vol_pct.sv
// ----------------------------------------------------------------------------
// acc_vol_pct
// Maps a signed 8.8 dB volume, clamped to -90..0 dB, onto 0..100 percent.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_vol_pct
  import acc_pkg::*;
(
  input  wire logic [15:0] raw,
  output logic      [6:0]  pct
);

  logic signed [15:0] sv;
  logic [14:0]        span_n;
  logic [16:0]        times5;
  logic [9:0]         t;
  logic [22:0]        prod;

  always_comb begin
    sv = signed'(raw);
    if (sv < VOL_MIN_DB256) begin
      span_n = '0;
    end else if (sv > 16'sd0) begin
      span_n = VOL_SPAN;
    end else begin
      span_n = 15'(sv - VOL_MIN_DB256);
    end
    // n*100/23040 == floor(floor(5n/128)/9)
    times5 = {span_n, 2'b00} + {2'b00, span_n};
    t      = times5[16:7];
    prod   = 23'(t) * 23'(DIV9_RECIP);
    pct    = prod[22:16];
  end

endmodule

`default_nettype wire

FILE: rtl/acc_ctrl.sv
// ----------------------------------------------------------------------------
// acc_ctrl
// Request decode, control state and result formation for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_ctrl
  import acc_pkg::*;
#(
  parameter int MAX_DATA_LENGTH = ACC_MAX_DATA_LENGTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    fire,
  input  wire acc_in_t item,
  output acc_out_t     result
);

  localparam int PLEN_W = $clog2(MAX_DATA_LENGTH);
  localparam int CMP_W  = (PLEN_W > 6) ? PLEN_W : 6;

  logic              pending_r, pending_nxt;
  logic [4:0]        pend_rcp_r, pend_rcp_nxt;
  logic [7:0]        pend_sel_r, pend_sel_nxt;
  logic [PLEN_W-1:0] pend_len_r, pend_len_nxt;
  logic              mute_r, mute_nxt;
  logic [15:0]       vol_db_r, vol_db_nxt;
  logic [6:0]        vol_pct_r, vol_pct_nxt;
  logic              rate_low_r, rate_low_nxt;

  logic [6:0]        pct_calc;
  logic [4:0]        rcp;
  logic [7:0]        sel;
  logic              len_ok;
  logic              count_ok;
  logic [15:0]       cur_rate;
  acc_status_t       status;
  logic [23:0]       rdata;
  logic [1:0]        rlen;

  acc_vol_pct u_vol_pct (
    .raw (item.payload[15:0]),
    .pct (pct_calc)
  );

  always_comb begin
    rcp      = item.request_type[4:0];
    sel      = item.value_word[15:8];
    len_ok   = (item.length_word != 16'd0) &&
               ({1'b0, item.length_word} < 17'(MAX_DATA_LENGTH));
    count_ok = CMP_W'(item.data_count) >= CMP_W'(pend_len_r);
    cur_rate = rate_low_r ? RATE_LOW : RATE_HIGH;

    pending_nxt  = pending_r;
    pend_rcp_nxt = pend_rcp_r;
    pend_sel_nxt = pend_sel_r;
    pend_len_nxt = pend_len_r;
    mute_nxt     = mute_r;
    vol_db_nxt   = vol_db_r;
    vol_pct_nxt  = vol_pct_r;
    rate_low_nxt = rate_low_r;
    status       = ST_STALL;
    rdata        = '0;
    rlen         = '0;

    if (item.kind) begin
      // data stage
      if (pending_r) begin
        pending_nxt = 1'b0;
        status      = ST_CLOSED;
        if (count_ok) begin
          if (pend_rcp_r == RCP_IFACE && pend_sel_r == SEL_MUTE) begin
            mute_nxt = item.payload[7:0] != 8'd0;
          end else if (pend_rcp_r == RCP_IFACE && pend_sel_r == SEL_VOLUME) begin
            vol_db_nxt  = item.payload[15:0];
            vol_pct_nxt = pct_calc;
          end else if (pend_rcp_r == RCP_ENDPOINT && pend_sel_r == SEL_RATE) begin
            if (item.payload != 24'd0 && item.payload != 24'(cur_rate)) begin
              rate_low_nxt = item.payload == 24'(RATE_LOW);
            end
          end
        end
      end
    end else begin
      // setup: always drops a pending request
      pending_nxt = 1'b0;
      if (item.request_type[6:5] == TYPE_CLASS) begin
        case (item.request_code)
          REQ_SET_CUR: begin
            if (len_ok) begin
              pending_nxt  = 1'b1;
              pend_rcp_nxt = rcp;
              pend_sel_nxt = sel;
              pend_len_nxt = item.length_word[PLEN_W-1:0];
              status       = ST_WAIT;
            end
          end
          REQ_GET_CUR: begin
            if (rcp == RCP_IFACE && sel == SEL_MUTE) begin
              status = ST_REPLY;
              rdata  = {23'd0, mute_r};
              rlen   = 2'd1;
            end else if (rcp == RCP_IFACE && sel == SEL_VOLUME) begin
              status = ST_REPLY;
              rdata  = {8'd0, vol_db_r};
              rlen   = 2'd2;
            end else if (rcp == RCP_ENDPOINT && sel == SEL_RATE) begin
              status = ST_REPLY;
              rdata  = 24'(cur_rate);
              rlen   = 2'd3;
            end
          end
          REQ_GET_MIN, REQ_GET_MAX, REQ_GET_RES: begin
            if (rcp == RCP_IFACE && sel == SEL_VOLUME) begin
              status = ST_REPLY;
              rlen   = 2'd2;
              case (item.request_code)
                REQ_GET_MIN: rdata = {8'd0, VOL_MIN_DB256};
                REQ_GET_MAX: rdata = {8'd0, VOL_MAX_DB256};
                default:     rdata = {8'd0, VOL_RES_DB256};
              endcase
            end
          end
          default: status = ST_STALL;
        endcase
      end
    end

    result.status        = status;
    result.reply_data    = rdata;
    result.reply_len     = rlen;
    result.mute_now      = mute_nxt;
    result.vol_percent   = vol_pct_nxt;
    result.sample_rate   = rate_low_nxt ? RATE_LOW : RATE_HIGH;
    result.feedback_word = rate_low_nxt ? FB_LOW : FB_HIGH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      pend_rcp_r <= '0;
      pend_sel_r <= '0;
      pend_len_r <= '0;
      mute_r     <= 1'b0;
      vol_db_r   <= '0;
      vol_pct_r  <= PCT_RESET;
      rate_low_r <= 1'b0;
    end else if (fire) begin
      pending_r  <= pending_nxt;
      pend_rcp_r <= pend_rcp_nxt;
      pend_sel_r <= pend_sel_nxt;
      pend_len_r <= pend_len_nxt;
      mute_r     <= mute_nxt;
      vol_db_r   <= vol_db_nxt;
      vol_pct_r  <= vol_pct_nxt;
      rate_low_r <= rate_low_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/audio_class_control_responder_top.sv
// ----------------------------------------------------------------------------
// audio_class_control_responder_top
// USB audio class 1 feature unit / endpoint control request responder.
// ----------------------------------------------------------------------------
// Each input word is either a setup packet (kind 0) or the data stage of a
// pending SET_CUR (kind 1); every word yields exactly one result word with a
// status (reply, awaiting data, stall, data stage closed), up to three reply
// bytes, and the current mute, volume percent, sample rate and 6.14 feedback
// word as they stand after that request. The block takes one word per clock
// while in_stall is low: a word is captured in the input register, decoded
// and applied against the control state in one pass, and lands in the output
// register when that register can take it. The control state is written at
// the same edge as the output register, so back-to-back requests see each
// other's effects. The output register frees the input side: a new word is
// accepted while a result waits, and in_stall rises only when both registers
// are full and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_class_control_responder_top
  import acc_pkg::*;
#(
  parameter int MAX_DATA_LENGTH = ACC_MAX_DATA_LENGTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire acc_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output acc_out_t     out_data
);

`include "audio_class_control_responder_top_defines.svh"

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  acc_in_t  s1_item_r;
  // output register
  logic     out_valid_r, out_valid_nxt;
  acc_out_t out_data_r;

  logic     advance;   // output register can take a word this cycle
  logic     fire;      // word in input register is processed this cycle
  acc_out_t result;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  acc_ctrl #(
    .MAX_DATA_LENGTH (MAX_DATA_LENGTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks ----
  `ACC_ASSERT_NOW(a_stall_needs_full, in_stall, s1_valid_r && out_valid_r,
    "input stalled with a free register")
  `ACC_ASSERT_NOW(a_fb_matches_rate, out_valid,
    (out_data.sample_rate == RATE_LOW) == (out_data.feedback_word == FB_LOW),
    "feedback word disagrees with sample rate")
  `ACC_ASSERT_NOW(a_reply_only_on_reply, out_valid && out_data.status != ST_REPLY,
    out_data.reply_len == 2'd0 && out_data.reply_data == 24'd0,
    "reply bytes on a non-reply status")
  `ACC_ASSERT_NEXT(a_pct_range, fire, result.vol_percent <= PCT_RESET,
    "volume percent above 100")

endmodule

`default_nettype wire
